/* hw/rtl/bra_pkg.sv */
// Package for the bitmap run allocator.
// Holds the field widths, command and status codes, controller states and
// the command/status structs between the controller and the datapath.
package bra_pkg;

  localparam int DEF_MAP_UNITS = 1024;

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 10;
  localparam int LEN_W     = 11;
  localparam int SIZE_W    = 11;
  localparam int STATUS_W  = 2;
  localparam int UNIT_W    = 12;
  localparam int WORD_BITS = 8;

  localparam logic [SIZE_W-1:0] MAP_SIZE_RESET = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_TEST  = 2'd2,
    CMD_MARK  = 2'd3
  } cmd_t;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_RMW_RD,
    S_RMW_WR,
    S_TEST,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic capture;
    logic decode;
    logic scan;
    logic rmw_start;
    logic rmw_step;
    logic test;
    logic load;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic clr_last;
    cmd_t req_cmd;
    logic req_reject;
    logic req_empty;
    logic scan_hit;
    logic scan_last;
    logic rmw_last;
  } ctrl_stat_t;

endpackage

/* hw/rtl/bra_ifc.sv */
// Valid/ready channel interfaces for the bitmap run allocator.
// Depends on bra_pkg for field widths and the command type.
interface bra_req_if;
  logic                       valid;
  logic                       ready;
  bra_pkg::cmd_t              cmd;
  logic [bra_pkg::IDX_W-1:0]  unit_index;
  logic [bra_pkg::LEN_W-1:0]  run_length;
  logic                       mark_value;

  modport source (output valid, cmd, unit_index, run_length, mark_value, input ready);
  modport sink   (input valid, cmd, unit_index, run_length, mark_value, output ready);
endinterface

interface bra_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bra_pkg::STATUS_W-1:0]  status;
  logic [bra_pkg::IDX_W-1:0]     run_start;
  logic                          unit_free;

  modport source (output valid, status, run_start, unit_free, input ready);
  modport sink   (input valid, status, run_start, unit_free, output ready);
endinterface

/* hw/rtl/bra_ctrl.sv */
// Controller state machine of the bitmap run allocator.
// Depends on bra_pkg; drives datapath commands and the channel handshakes.
module bra_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output bra_pkg::ctrl_cmd_t  cmd,
  input  bra_pkg::ctrl_stat_t stat
);
  import bra_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;

    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (stat.req_reject) begin
          state_nxt = S_FINISH;
        end else begin
          unique case (stat.req_cmd) inside
            CMD_ALLOC:          state_nxt = S_SCAN;
            CMD_FREE:           state_nxt = stat.req_empty ? S_FINISH : S_RMW_RD;
            CMD_TEST, CMD_MARK: state_nxt = S_RMW_RD;
            default:            state_nxt = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_hit) state_nxt = S_RMW_RD;
        else if (stat.scan_last) state_nxt = S_FINISH;
      end
      S_RMW_RD: begin
        cmd.rmw_start = 1'b1;
        state_nxt     = (stat.req_cmd == CMD_TEST) ? S_TEST : S_RMW_WR;
      end
      S_RMW_WR: begin
        cmd.rmw_step = 1'b1;
        if (stat.rmw_last) state_nxt = S_FINISH;
      end
      S_TEST: begin
        cmd.test  = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // The result register is reloaded only once the previous result has gone.
        if (!out_valid_r || out_ready) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/bra_datapath.sv */
// Datapath of the bitmap run allocator: occupancy memory, request and
// result registers, run scanner and read-modify-write marker. Uses bra_pkg.
module bra_datapath #(
  parameter int MAP_UNITS = bra_pkg::DEF_MAP_UNITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [bra_pkg::SIZE_W-1:0]       cfg_wr_data,
  input  bra_pkg::cmd_t                    in_cmd,
  input  logic [bra_pkg::IDX_W-1:0]        in_unit_index,
  input  logic [bra_pkg::LEN_W-1:0]        in_run_length,
  input  logic                             in_mark_value,
  input  bra_pkg::ctrl_cmd_t               cmd,
  output bra_pkg::ctrl_stat_t              stat,
  output logic [bra_pkg::STATUS_W-1:0]     out_status,
  output logic [bra_pkg::IDX_W-1:0]        out_run_start,
  output logic                             out_unit_free
);
  import bra_pkg::*;

  localparam int STORE_WORDS = (MAP_UNITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

  // Occupancy memory, one bit per unit, set means used.
  logic [WORD_BITS-1:0] mem [STORE_WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic [SIZE_W-1:0]    map_size_r;
  logic [SIZE_W-1:0]    eff_size;
  logic [SIZE_W-1:0]    size_r;
  cmd_t                 req_cmd_r;
  logic [IDX_W-1:0]     req_idx_r;
  logic [LEN_W-1:0]     req_len_r;
  logic                 req_mval_r;

  logic [UNIT_W-1:0]    scan_base_r;
  logic [LEN_W-1:0]     matched_r;
  logic [UNIT_W-1:0]    mk_first_r;
  logic [UNIT_W-1:0]    mk_end_r;
  logic                 mk_val_r;
  logic [UNIT_W-1:0]    rw_base_r;
  logic [AW-1:0]        clr_addr_r;

  logic [STATUS_W-1:0]  res_status_r;
  logic [IDX_W-1:0]     res_start_r;
  logic                 res_free_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [IDX_W-1:0]     out_start_r;
  logic                 out_free_r;

  logic [UNIT_W-1:0]    scan_u;
  logic [LEN_W-1:0]     scan_m;
  logic                 scan_hit;
  logic [UNIT_W-1:0]    hit_start;
  logic                 scan_last;
  logic [UNIT_W-1:0]    free_end;
  logic                 free_oob;
  logic                 unit_oob;
  logic                 req_reject;
  logic [UNIT_W-1:0]    rw_u;
  logic [WORD_BITS-1:0] rw_mask;
  logic [WORD_BITS-1:0] rw_word;

  function automatic logic [AW-1:0] word_of(input logic [UNIT_W-1:0] u);
    return AW'(u[UNIT_W-1:3]);
  endfunction

  assign eff_size = (32'(map_size_r) < MAP_UNITS) ? map_size_r : SIZE_W'(MAP_UNITS);

  // Request checks on the captured request.
  assign free_end = {2'b00, req_idx_r} + {1'b0, req_len_r};
  assign free_oob = free_end > {1'b0, size_r};
  assign unit_oob = {1'b0, req_idx_r} >= size_r;

  always_comb begin
    case (req_cmd_r)
      CMD_ALLOC: req_reject = (req_len_r == '0);
      CMD_FREE:  req_reject = free_oob;
      default:   req_reject = unit_oob;
    endcase
  end

  // First-fit scan over the eight units of the word in rdata_r.
  always_comb begin
    scan_m    = matched_r;
    scan_hit  = 1'b0;
    hit_start = '0;
    scan_u    = scan_base_r;
    for (int b = 0; b < WORD_BITS; b++) begin
      scan_u = scan_base_r + UNIT_W'(b);
      if (!scan_hit && (scan_u < {1'b0, size_r})) begin
        if (!rdata_r[b]) begin
          scan_m = scan_m + 1'b1;
          if (scan_m == req_len_r) begin
            scan_hit  = 1'b1;
            hit_start = scan_u + 1'b1 - {1'b0, req_len_r};
          end
        end else begin
          scan_m = '0;
        end
      end
    end
  end

  assign scan_last = (scan_base_r + UNIT_W'(WORD_BITS)) >= {1'b0, size_r};

  // Bits of the current word that fall inside the run being marked.
  always_comb begin
    rw_mask = '0;
    rw_u    = rw_base_r;
    for (int b = 0; b < WORD_BITS; b++) begin
      rw_u       = rw_base_r + UNIT_W'(b);
      rw_mask[b] = (rw_u >= mk_first_r) && (rw_u < mk_end_r);
    end
  end

  assign rw_word = mk_val_r ? (rdata_r | rw_mask) : (rdata_r & ~rw_mask);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.decode) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd.scan) begin
      rd_en   = 1'b1;
      rd_addr = word_of(scan_base_r + UNIT_W'(WORD_BITS));
    end else if (cmd.rmw_start) begin
      rd_en   = 1'b1;
      rd_addr = word_of(mk_first_r);
    end else if (cmd.rmw_step) begin
      rd_en   = 1'b1;
      rd_addr = word_of(rw_base_r + UNIT_W'(WORD_BITS));
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr_r;
    wr_data = '0;
    if (cmd.clr_step) begin
      wr_en = 1'b1;
    end else if (cmd.rmw_step) begin
      wr_en   = 1'b1;
      wr_addr = word_of(rw_base_r);
      wr_data = rw_word;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_size_r <= MAP_SIZE_RESET;
      clr_addr_r <= '0;
    end else begin
      if (cfg_wr_en) map_size_r <= cfg_wr_data;
      if (cmd.clr_step) clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      size_r     <= eff_size;
      req_cmd_r  <= in_cmd;
      req_idx_r  <= in_unit_index;
      req_len_r  <= in_run_length;
      req_mval_r <= in_mark_value;
    end

    if (cmd.decode) begin
      if (req_reject) begin
        res_status_r <= (req_cmd_r == CMD_ALLOC) ? ST_NO_SPACE : ST_RANGE;
      end else begin
        res_status_r <= ST_OK;
      end
      res_start_r <= '0;
      res_free_r  <= 1'b0;
      scan_base_r <= '0;
      matched_r   <= '0;
      mk_first_r  <= {2'b00, req_idx_r};
      mk_end_r    <= (req_cmd_r == CMD_FREE) ? free_end : ({2'b00, req_idx_r} + 1'b1);
      mk_val_r    <= (req_cmd_r == CMD_MARK) ? req_mval_r : 1'b0;
    end

    if (cmd.scan) begin
      if (scan_hit) begin
        res_start_r <= hit_start[IDX_W-1:0];
        mk_first_r  <= hit_start;
        mk_end_r    <= hit_start + {1'b0, req_len_r};
        mk_val_r    <= 1'b1;
      end else if (scan_last) begin
        res_status_r <= ST_NO_SPACE;
      end else begin
        scan_base_r <= scan_base_r + UNIT_W'(WORD_BITS);
        matched_r   <= scan_m;
      end
    end

    if (cmd.rmw_start) rw_base_r <= {mk_first_r[UNIT_W-1:3], 3'b000};
    if (cmd.rmw_step)  rw_base_r <= rw_base_r + UNIT_W'(WORD_BITS);
    if (cmd.test)      res_free_r <= ~rdata_r[mk_first_r[2:0]];

    if (cmd.load) begin
      out_status_r <= res_status_r;
      out_start_r  <= res_start_r;
      out_free_r   <= res_free_r;
    end
  end

  assign stat.clr_last   = (clr_addr_r == AW'(STORE_WORDS - 1));
  assign stat.req_cmd    = req_cmd_r;
  assign stat.req_reject = req_reject;
  assign stat.req_empty  = (req_len_r == '0);
  assign stat.scan_hit   = scan_hit;
  assign stat.scan_last  = scan_last;
  assign stat.rmw_last   = (rw_base_r + UNIT_W'(WORD_BITS)) >= mk_end_r;

  assign out_status    = out_status_r;
  assign out_run_start = out_start_r;
  assign out_unit_free = out_free_r;

endmodule

/* hw/rtl/bitmap_run_allocator.sv */
// Bitmap run allocator, top level.
// Requests arrive on in_ch (valid/ready) with cmd, unit_index, run_length and
// mark_value; one result per request leaves on out_ch with status, run_start
// and unit_free. cfg_wr_en/cfg_wr_data write map_size, the number of units
// managed, and must only be used while the block is idle.
// One request is handled at a time. An accepted request is decoded; a
// rejected one goes straight to the result. A test reads the word holding the
// unit; mark and in-range free read and rewrite each memory word the run
// touches; alloc scans words (one word per cycle) until the run fits or the
// map ends, then marks the words of the run. The occupancy memory has one
// word read and one word written per cycle.
// After reset a clearing pass writes every memory word to zero, during which
// in_ch.ready stays low; map_size resets to 1024. A result waits in the output
// register until taken, and the next transaction may be accepted meanwhile;
// it completes once the register frees.
module bitmap_run_allocator #(
  parameter int MAP_UNITS = bra_pkg::DEF_MAP_UNITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bra_req_if.sink                     in_ch,
  bra_rsp_if.source                   out_ch,
  input  logic                        cfg_wr_en,
  input  logic [bra_pkg::SIZE_W-1:0]  cfg_wr_data
);
  import bra_pkg::*;

  ctrl_cmd_t  ctl_cmd;
  ctrl_stat_t ctl_stat;

  bra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (ctl_cmd),
    .stat      (ctl_stat)
  );

  bra_datapath #(
    .MAP_UNITS (MAP_UNITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_cmd        (in_ch.cmd),
    .in_unit_index (in_ch.unit_index),
    .in_run_length (in_ch.run_length),
    .in_mark_value (in_ch.mark_value),
    .cmd           (ctl_cmd),
    .stat          (ctl_stat),
    .out_status    (out_ch.status),
    .out_run_start (out_ch.run_start),
    .out_unit_free (out_ch.unit_free)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the bitmap run allocator: a queue-fed request driver,
// a result monitor and an occupancy-map predictor. Depends on bra_pkg, the
// bra_req_if/bra_rsp_if interfaces and the bitmap_run_allocator top level.
module tb;
  import bra_pkg::*;

  typedef struct {
    cmd_t             cmd;
    logic [IDX_W-1:0] unit_index;
    logic [LEN_W-1:0] run_length;
    logic             mark_value;
  } alloc_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    run_start;
    logic                unit_free;
  } alloc_reply_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [SIZE_W-1:0] cfg_wr_data;

  bra_req_if req_bus ();
  bra_rsp_if rsp_bus ();

  bitmap_run_allocator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (req_bus),
    .out_ch      (rsp_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  bit           unit_used [DEF_MAP_UNITS];
  int           units_managed;
  alloc_req_t   pending_q [$];
  alloc_reply_t reply_q [$];
  int           in_flight = 0;
  int           mismatches = 0;
  int           replies_seen = 0;
  bit           req_fire = 1'b0;
  int           tx_gap = 0;
  int           rx_hold = 0;
  int           next_long_hold = 300;
  bit           tx_burst = 1'b0;
  bit           rx_burst = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Updates the occupancy map for one request and returns the result it should give.
  function automatic alloc_reply_t apply_request(alloc_req_t rq);
    alloc_reply_t rp;
    int lim, len, idx, run, first, u;
    bit hit;
    lim = (units_managed < DEF_MAP_UNITS) ? units_managed : DEF_MAP_UNITS;
    len = rq.run_length;
    idx = rq.unit_index;
    rp.status = ST_OK;
    rp.run_start = '0;
    rp.unit_free = 1'b0;
    hit = 1'b0;
    run = 0;
    first = 0;
    case (rq.cmd)
      CMD_ALLOC: begin
        if (len != 0) begin
          for (u = 0; u < lim && !hit; u++) begin
            if (unit_used[u]) begin
              run = 0;
            end else begin
              run++;
              if (run == len) begin
                hit = 1'b1;
                first = u + 1 - len;
              end
            end
          end
        end
        if (hit) begin
          for (u = first; u < first + len; u++) unit_used[u] = 1'b1;
          rp.run_start = IDX_W'(first);
        end else begin
          rp.status = ST_NO_SPACE;
        end
      end
      CMD_FREE: begin
        if (idx + len > lim) rp.status = ST_RANGE;
        else for (u = idx; u < idx + len; u++) unit_used[u] = 1'b0;
      end
      CMD_TEST: begin
        if (idx >= lim) rp.status = ST_RANGE;
        else rp.unit_free = !unit_used[idx];
      end
      default: begin
        if (idx >= lim) rp.status = ST_RANGE;
        else unit_used[idx] = rq.mark_value;
      end
    endcase
    return rp;
  endfunction

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly in-range indexes and short runs, with a share of odd lengths and stray indexes.
  function automatic alloc_req_t random_request();
    alloc_req_t rq;
    int lim, pick;
    lim = (units_managed < DEF_MAP_UNITS) ? units_managed : DEF_MAP_UNITS;
    pick = $urandom_range(0, 99);
    rq.cmd = (pick < 40) ? CMD_ALLOC : (pick < 65) ? CMD_FREE :
             (pick < 82) ? CMD_TEST : CMD_MARK;
    if (lim > 0 && $urandom_range(0, 99) < 85) rq.unit_index = IDX_W'($urandom_range(0, lim - 1));
    else rq.unit_index = IDX_W'($urandom());
    rq.run_length = LEN_W'($urandom());
    rq.mark_value = 1'($urandom());
    pick = $urandom_range(0, 99);
    if (rq.cmd == CMD_ALLOC) begin
      if (pick < 70) rq.run_length = LEN_W'($urandom_range(1, 16));
      else if (pick < 88) rq.run_length = LEN_W'($urandom_range(1, lim + 1));
      else if (pick < 93) rq.run_length = '0;
    end else if (rq.cmd == CMD_FREE) begin
      if (pick < 75) rq.run_length = LEN_W'($urandom_range(0, 16));
      else if (pick < 92) rq.run_length = LEN_W'($urandom_range(0, lim));
    end
    return rq;
  endfunction

  task automatic queue_request(cmd_t c, int idx, int len, bit mval);
    alloc_req_t rq;
    rq.cmd = c;
    rq.unit_index = IDX_W'(idx);
    rq.run_length = LEN_W'(len);
    rq.mark_value = mval;
    pending_q.push_back(rq);
    in_flight++;
  endtask

  task automatic queue_random(int count);
    repeat (count) begin
      pending_q.push_back(random_request());
      in_flight++;
    end
  endtask

  // The block must be idle for a size change, so every outstanding result is collected first.
  task automatic write_map_size(int value);
    wait (in_flight == 0);
    repeat (6) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= SIZE_W'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    units_managed = value;
  endtask

  // Request driver.
  always @(negedge clk) begin
    alloc_req_t nxt;
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_fire) begin
      if (tx_gap > 0) begin
        req_bus.valid <= 1'b0;
        tx_gap--;
      end else if (pending_q.size() != 0) begin
        nxt = pending_q.pop_front();
        req_bus.cmd        <= nxt.cmd;
        req_bus.unit_index <= nxt.unit_index;
        req_bus.run_length <= nxt.run_length;
        req_bus.mark_value <= nxt.mark_value;
        req_bus.valid      <= 1'b1;
        tx_gap = pick_gap(tx_burst);
      end else begin
        req_bus.valid <= 1'b0;
      end
      if ($urandom_range(0, 149) == 0) tx_burst = !tx_burst;
    end
  end

  // Predicts each request transaction as it is accepted.
  always @(posedge clk) begin
    alloc_req_t seen;
    req_fire = rst_n && req_bus.valid && req_bus.ready;
    if (req_fire) begin
      seen.cmd        = req_bus.cmd;
      seen.unit_index = req_bus.unit_index;
      seen.run_length = req_bus.run_length;
      seen.mark_value = req_bus.mark_value;
      reply_q.push_back(apply_request(seen));
    end
  end

  // Result receiver: random back-pressure, with a long hold-off every few hundred results.
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rsp_bus.ready <= 1'b0;
      rx_hold--;
    end else if (replies_seen >= next_long_hold) begin
      // Long enough for the output register to fill and the request side to stall.
      rsp_bus.ready <= 1'b0;
      rx_hold = 250;
      next_long_hold += 350;
    end else if (rx_burst || $urandom_range(0, 99) < 70) begin
      rsp_bus.ready <= 1'b1;
    end else begin
      rsp_bus.ready <= 1'b0;
      rx_hold = pick_gap(1'b0);
    end
    if ($urandom_range(0, 199) == 0) rx_burst = !rx_burst;
  end

  // Result monitor.
  always @(posedge clk) begin
    alloc_reply_t want;
    if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
      replies_seen++;
      if (reply_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result transaction with none expected: status %0d start %0d free %0d",
                   $realtime, rsp_bus.status, rsp_bus.run_start, rsp_bus.unit_free);
      end else begin
        want = reply_q.pop_front();
        in_flight--;
        if (rsp_bus.status !== want.status || rsp_bus.run_start !== want.run_start ||
            rsp_bus.unit_free !== want.unit_free) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected status %0d start %0d free %0d, got %0d %0d %0d",
                     $realtime, want.status, want.run_start, want.unit_free,
                     rsp_bus.status, rsp_bus.run_start, rsp_bus.unit_free);
        end
      end
    end
  end

  initial begin
    req_bus.valid = 1'b0;
    req_bus.cmd = CMD_ALLOC;
    req_bus.unit_index = '0;
    req_bus.run_length = '0;
    req_bus.mark_value = 1'b0;
    rsp_bus.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    rst_n = 1'b0;
    units_managed = MAP_SIZE_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // The clearing pass holds ready low; wait it out before anything else.
    wait (req_bus.ready === 1'b1);

    // Directed checks on the full map, starting from all units free.
    queue_request(CMD_TEST, 0, 0, 1'b0);
    queue_request(CMD_ALLOC, 0, 0, 1'b0);
    queue_request(CMD_ALLOC, 0, 1, 1'b0);
    queue_request(CMD_ALLOC, 0, 1024, 1'b0);
    queue_request(CMD_ALLOC, 0, 1023, 1'b0);
    queue_request(CMD_TEST, 1023, 0, 1'b0);
    queue_request(CMD_ALLOC, 0, 1, 1'b0);
    queue_request(CMD_FREE, 1023, 2, 1'b0);
    queue_request(CMD_FREE, 0, 1024, 1'b0);
    queue_request(CMD_FREE, 0, 0, 1'b0);
    queue_request(CMD_ALLOC, 0, 2047, 1'b0);
    queue_request(CMD_ALLOC, 0, 1024, 1'b0);
    queue_request(CMD_FREE, 1023, 1, 1'b0);
    queue_request(CMD_TEST, 1023, 0, 1'b0);
    queue_request(CMD_FREE, 0, 1023, 1'b0);
    queue_request(CMD_MARK, 5, 0, 1'b1);
    queue_request(CMD_MARK, 1023, 0, 1'b1);
    queue_request(CMD_ALLOC, 0, 8, 1'b0);
    queue_request(CMD_TEST, 5, 0, 1'b0);
    queue_request(CMD_MARK, 5, 0, 1'b0);
    queue_request(CMD_TEST, 1023, 2047, 1'b1);
    queue_request(CMD_FREE, 0, 1024, 1'b0);
    queue_random(150);

    // Oversized, empty, tiny, odd-sized and partial maps, then back to the full map.
    write_map_size(2047);
    queue_random(100);
    write_map_size(0);
    queue_random(20);
    write_map_size(8);
    queue_random(80);
    write_map_size(13);
    queue_random(80);
    write_map_size(64);
    queue_random(120);
    write_map_size(1000);
    queue_random(120);
    write_map_size(200);
    queue_random(100);
    write_map_size(1024);
    queue_random(180);

    wait (in_flight == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bra_pkg.sv
hw/rtl/bra_ifc.sv
hw/rtl/bra_ctrl.sv
hw/rtl/bra_datapath.sv
hw/rtl/bitmap_run_allocator.sv
tb/tb.sv
